>>> rtl/core/ils_pkg.sv
// Shared types and constants for the indexed list store.
// Used by the front end, the job queue, the back end and the top level.
package ils_pkg;

  localparam int Capacity = 64;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CntW     = 7;
  localparam int PosW     = 7;
  localparam int DataW    = 32;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_POP    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Memory work the back end has to do for one transaction.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_APPEND = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5,
    OP_POP    = 3'd6
  } op_e;

  typedef struct packed {
    op_e               op;
    status_e           status;
    logic [AddrW-1:0]  pos;        // target entry (append and pop resolved here)
    logic [CntW-1:0]   cnt;        // entry count before the command
    logic [CntW-1:0]   cnt_after;  // entry count after the command
    logic [DataW-1:0]  value;
  } job_t;

endpackage

>>> rtl/core/ils_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module ils_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ils_front.sv
// Front end: accepts commands, tracks the entry count and classifies each command
// into a back-end job with its final status. Depends on ils_pkg.
module ils_front import ils_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      cmd_i,
  input  logic [PosW-1:0] position_i,
  input  logic [31:0]     value_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output job_t            q_job_o
);

  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            pos_in_list;
  logic            list_full;
  job_t            job;

  assign pos_in_list = position_i < PosW'(count_q);
  assign list_full   = count_q >= CntW'(Capacity);

  always_comb begin
    job           = '0;
    job.op        = OP_NONE;
    job.status    = ST_OK;
    job.pos       = position_i[AddrW-1:0];
    job.cnt       = count_q;
    job.cnt_after = count_q;
    job.value     = value_i;
    case (cmd_e'(cmd_i))
      CMD_READ: begin
        if (pos_in_list) job.op = OP_READ;
        else             job.status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (pos_in_list) job.op = OP_WRITE;
        else             job.status = ST_RANGE;
      end
      CMD_APPEND: begin
        if (list_full) begin
          job.status = ST_FULL;
        end else begin
          job.op        = OP_APPEND;
          job.pos       = count_q[AddrW-1:0];
          job.cnt_after = count_q + CntW'(1);
        end
      end
      CMD_INSERT: begin
        if (position_i > PosW'(count_q)) begin
          job.status = ST_RANGE;
        end else if (list_full) begin
          job.status = ST_FULL;
        end else begin
          job.op        = OP_INSERT;
          job.cnt_after = count_q + CntW'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_in_list) begin
          job.op        = OP_REMOVE;
          job.cnt_after = count_q - CntW'(1);
        end else begin
          job.status = ST_RANGE;
        end
      end
      CMD_POP: begin
        if (count_q == '0) begin
          job.status = ST_EMPTY;
        end else begin
          job.op        = OP_POP;
          job.cnt_after = count_q - CntW'(1);
          job.pos       = job.cnt_after[AddrW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;
  assign q_job_o    = job;
  assign count_d    = accept ? job.cnt_after : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/core/ils_queue.sv
// Short job queue between the front end and the back end.
// Depends on ils_pkg for the job type and the queue depth.
module ils_queue import ils_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  job_t             slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = fill_q == (QPtrW+1)'(QDepth);
  assign valid_o = fill_q != '0;
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) fill_d = fill_q + (QPtrW+1)'(1);
    if (!do_push && do_pop) fill_d = fill_q - (QPtrW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> rtl/core/ils_back.sv
// Back end: executes queued jobs against the list memory, moving one entry per
// cycle for insert and remove, and holds the result register. Depends on ils_pkg, ils_ram.
module ils_back import ils_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  job_t             q_job_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] read_value_o,
  output logic [1:0]       status_o,
  output logic [CntW-1:0]  count_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_LAST  = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  job_t             job_q, job_d;
  logic [AddrW-1:0] src_q, src_d;
  logic [DataW-1:0] rv_q, rv_d;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_value_q, out_value_d;
  status_e          out_status_q, out_status_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;
  logic             out_load;

  ils_ram #(
    .Width(DataW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    src_d     = src_q;
    rv_d      = rv_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = job_q.pos;
    ram_wdata = job_q.value;
    ram_re    = 1'b0;
    ram_raddr = job_q.pos;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          job_d     = q_job_i;
          ram_waddr = q_job_i.pos;
          ram_wdata = q_job_i.value;
          ram_raddr = q_job_i.pos;
          state_d   = S_FIN;
          case (q_job_i.op)
            OP_READ, OP_POP: ram_re = 1'b1;
            OP_WRITE, OP_APPEND: ram_we = 1'b1;
            OP_INSERT: begin
              if (q_job_i.cnt > CntW'(q_job_i.pos)) begin
                // Start at the top entry and move upward one slot at a time.
                ram_re    = 1'b1;
                ram_raddr = AddrW'(q_job_i.cnt - CntW'(1));
                src_d     = AddrW'(q_job_i.cnt - CntW'(1));
                state_d   = S_SHIFT;
              end else begin
                ram_we = 1'b1;
              end
            end
            OP_REMOVE: begin
              ram_re  = 1'b1;
              src_d   = q_job_i.pos;
              state_d = S_SHIFT;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        ram_wdata = ram_rdata;
        if (job_q.op == OP_INSERT) begin
          ram_we    = 1'b1;
          ram_waddr = src_q + AddrW'(1);
          if (src_q > job_q.pos) begin
            ram_re    = 1'b1;
            ram_raddr = src_q - AddrW'(1);
            src_d     = src_q - AddrW'(1);
          end else begin
            state_d = S_LAST;
          end
        end else begin
          // Capture the removed entry, then pull each higher entry down.
          if (src_q == job_q.pos) begin
            rv_d = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = src_q - AddrW'(1);
          end
          if (CntW'(src_q) + CntW'(1) < job_q.cnt) begin
            ram_re    = 1'b1;
            ram_raddr = src_q + AddrW'(1);
            src_d     = src_q + AddrW'(1);
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_LAST: begin
        ram_we  = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_cnt_d    = out_cnt_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = job_q.status;
      out_cnt_d    = job_q.cnt_after;
      case (job_q.op)
        OP_READ, OP_POP: out_value_d = ram_rdata;
        OP_REMOVE:       out_value_d = rv_q;
        default:         out_value_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q        <= job_d;
    src_q        <= src_d;
    rv_q         <= rv_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;
  assign count_o      = out_cnt_q;

endmodule

>>> rtl/core/indexed_list_store_unit.sv
// Indexed list store: an ordered list of up to 64 signed 32-bit values with
// read, write, append, insert, remove and pop commands, one result per command.
// The front end takes a command in every cycle while its two-entry job queue has
// room; it resolves status and the new count at once. The back end works one job
// at a time through a single-write, registered-read list memory that moves one
// entry per cycle for insert and remove; an insert at the current count moves no
// entries. No clearing pass runs after reset; entries below the count are always
// written before they are read. Depends on ils_pkg.
module indexed_list_store_unit import ils_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       cmd_i,
  input  logic [PosW-1:0]  position_i,
  input  logic [DataW-1:0] value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] read_value_o,
  output logic [1:0]       status_o,
  output logic [CntW-1:0]  count_o
);

  logic q_push, q_full, q_valid, q_pop;
  job_t front_job, back_job;

  ils_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i     (cmd_i),
    .position_i(position_i),
    .value_i   (value_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (front_job)
  );

  ils_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (front_job),
    .full_o (q_full),
    .valid_o(q_valid),
    .job_o  (back_job),
    .pop_i  (q_pop)
  );

  ils_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (back_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  // An empty-list error can only report a zero count.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> count_o == '0)
    else $error("empty status with nonzero count");

  // A full-list error can only report a count at capacity.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CntW'(Capacity))
    else $error("full status below capacity");

  // Failed commands return no data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == '0)
    else $error("error result carries data");

  // The count never passes capacity.
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CntW'(Capacity))
    else $error("count above capacity");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for indexed_list_store_unit. Drives list commands over a
// valid/ready channel and checks every result against an in-bench list predictor
// or a directed row's listed result. Depends on ils_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
  import ils_pkg::*;

  localparam int RandomItems    = 800;
  localparam int HoldOffCycles  = 300;
  localparam int DrainCycles    = 80;
  localparam int WatchdogLimit  = 4000;
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  typedef struct {
    logic [DataW-1:0] read_value;
    status_e          status;
    logic [CntW-1:0]  count;
  } list_result_t;

  typedef struct {
    logic [2:0]       cmd;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] val;
    bit               typed;
    list_result_t     result;
  } list_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid_q = 1'b0;
  logic [2:0]       cmd_q = CMD_READ;
  logic [PosW-1:0]  pos_q = '0;
  logic [DataW-1:0] value_q = '0;
  logic             out_ready_q = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [DataW-1:0] read_value_o;
  logic [1:0]       status_o;
  logic [CntW-1:0]  count_o;

  // Predictor state: the list as the unit should hold it.
  logic [DataW-1:0] list_mem [Capacity];
  int               list_count = 0;

  list_result_t     pending_results [$];
  list_result_t     oldest_result;
  list_row_t        directed_rows [$];

  int list_commands   = 0;
  int results_checked = 0;
  int error_count     = 0;
  int full_hits       = 0;
  int empty_hits      = 0;
  int range_hits      = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_list_store_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid_q),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_q),
    .position_i   (pos_q),
    .value_i      (value_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_q),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

  function automatic list_result_t apply_list_command(logic [2:0] cmd, logic [PosW-1:0] pos,
                                                      logic [DataW-1:0] val);
    list_result_t r;
    int p;
    int k;
    r.read_value = '0;
    r.status     = ST_OK;
    p = int'(pos);
    case (cmd)
      CMD_READ: begin
        if (p < list_count) r.read_value = list_mem[p];
        else r.status = ST_RANGE;
      end
      CMD_WRITE: begin
        if (p < list_count) list_mem[p] = val;
        else r.status = ST_RANGE;
      end
      CMD_APPEND: begin
        if (list_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_count] = val;
          list_count++;
        end
      end
      CMD_INSERT: begin
        // Range is checked before capacity.
        if (p > list_count) begin
          r.status = ST_RANGE;
        end else if (list_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          for (k = list_count; k > p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p] = val;
          list_count++;
        end
      end
      CMD_REMOVE: begin
        if (p < list_count) begin
          r.read_value = list_mem[p];
          for (k = p; k + 1 < list_count; k++) list_mem[k] = list_mem[k+1];
          list_count--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      CMD_POP: begin
        if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_count--;
          r.read_value = list_mem[list_count];
        end
      end
      default: ;
    endcase
    r.count = list_count[CntW-1:0];
    return r;
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_row(input logic [2:0] cmd, input logic [PosW-1:0] pos,
                         input logic [DataW-1:0] val, input bit typed,
                         input logic [DataW-1:0] rv, input status_e st,
                         input logic [CntW-1:0] cnt);
    list_row_t row;
    row.cmd               = cmd;
    row.pos               = pos;
    row.val               = val;
    row.typed             = typed;
    row.result.read_value = rv;
    row.result.status     = st;
    row.result.count      = cnt;
    directed_rows.push_back(row);
  endtask

  // Offer one command, hold it until the transaction, then record its result.
  task automatic issue_command(input logic [2:0] cmd, input logic [PosW-1:0] pos,
                               input logic [DataW-1:0] val, input bit typed,
                               input list_result_t typed_result);
    list_result_t r;
    in_valid_q <= 1'b1;
    cmd_q      <= cmd;
    pos_q      <= pos;
    value_q    <= val;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    r = apply_list_command(cmd, pos, val);
    if (typed) r = typed_result;
    pending_results.push_back(r);
    if (cmd <= CMD_POP) list_commands++;
    case (r.status)
      ST_FULL:  full_hits++;
      ST_EMPTY: empty_hits++;
      ST_RANGE: range_hits++;
      default: ;
    endcase
  endtask

  // Bursts of back-to-back commands separated by random gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_q <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : stimulus
    list_result_t     none;
    logic [2:0]       cmd_pick;
    logic [PosW-1:0]  pos_pick;
    int               kind;
    int               n;
    int               directed_total;
    none.read_value = '0;
    none.status     = ST_OK;
    none.count      = '0;

    add_row(CMD_POP,    7'd0,   32'd0,          1, 32'd0,          ST_EMPTY, 7'd0);
    add_row(CMD_REMOVE, 7'd0,   32'd0,          1, 32'd0,          ST_RANGE, 7'd0);
    add_row(CMD_READ,   7'd0,   32'd0,          1, 32'd0,          ST_RANGE, 7'd0);
    add_row(CMD_WRITE,  7'd0,   32'd5,          1, 32'd0,          ST_RANGE, 7'd0);
    add_row(CMD_INSERT, 7'd1,   32'd9,          1, 32'd0,          ST_RANGE, 7'd0);
    add_row(CMD_INSERT, 7'd0,   32'h8000_0000,  1, 32'd0,          ST_OK,    7'd1);
    add_row(CMD_APPEND, 7'd0,   32'h7FFF_FFFF,  1, 32'd0,          ST_OK,    7'd2);
    // Insert at the end behaves as an append.
    add_row(CMD_INSERT, 7'd2,   32'hFFFF_FFFF,  1, 32'd0,          ST_OK,    7'd3);
    add_row(CMD_READ,   7'd0,   32'd0,          1, 32'h8000_0000,  ST_OK,    7'd3);
    add_row(CMD_READ,   7'd2,   32'd0,          1, 32'hFFFF_FFFF,  ST_OK,    7'd3);
    add_row(CMD_INSERT, 7'd1,   32'h0000_0001,  0, 32'd0,          ST_OK,    7'd0);
    add_row(CMD_WRITE,  7'd3,   32'h0000_0000,  0, 32'd0,          ST_OK,    7'd0);
    add_row(CMD_READ,   7'd127, 32'd0,          1, 32'd0,          ST_RANGE, 7'd4);
    add_row(CMD_REMOVE, 7'd4,   32'd0,          1, 32'd0,          ST_RANGE, 7'd4);
    add_row(CMD_REMOVE, 7'd1,   32'd0,          0, 32'd0,          ST_OK,    7'd0);
    add_row(CmdSpare6,  7'd127, 32'hFFFF_FFFF,  1, 32'd0,          ST_OK,    7'd3);
    add_row(CmdSpare7,  7'd64,  32'h5555_AAAA,  1, 32'd0,          ST_OK,    7'd3);
    add_row(CMD_WRITE,  7'd0,   32'h1234_5678,  0, 32'd0,          ST_OK,    7'd0);
    add_row(CMD_POP,    7'd0,   32'd0,          0, 32'd0,          ST_OK,    7'd0);
    add_row(CMD_REMOVE, 7'd0,   32'd0,          0, 32'd0,          ST_OK,    7'd0);
    add_row(CMD_POP,    7'd0,   32'd0,          0, 32'd0,          ST_OK,    7'd0);
    add_row(CMD_POP,    7'd0,   32'd0,          1, 32'd0,          ST_EMPTY, 7'd0);
    add_row(CMD_INSERT, 7'd64,  32'd1,          1, 32'd0,          ST_RANGE, 7'd0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      issue_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                    directed_rows[i].typed, directed_rows[i].result);
      pace_sender();
    end
    directed_total = list_commands;

    // Fill to capacity, drain to empty and churn in between; poke the
    // boundaries with random commands after each fill and after each drain.
    kind = 0;
    while (list_commands < directed_total + RandomItems) begin
      case (kind)
        0: begin
          while (list_count < Capacity) begin
            cmd_pick = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
            pos_pick = PosW'($urandom_range(0, list_count));
            issue_command(cmd_pick, pos_pick, pick_value(), 0, none);
            pace_sender();
          end
        end
        1: begin
          while (list_count > 0) begin
            cmd_pick = $urandom_range(0, 1) ? CMD_POP : CMD_REMOVE;
            pos_pick = PosW'($urandom_range(0, list_count - 1));
            issue_command(cmd_pick, pos_pick, pick_value(), 0, none);
            pace_sender();
          end
        end
        default: begin
          n = $urandom_range(20, 60);
          repeat (n) begin
            if ($urandom_range(0, 19) == 0) cmd_pick = $urandom_range(0, 1) ? CmdSpare6 : CmdSpare7;
            else cmd_pick = 3'($urandom_range(0, 5));
            if ($urandom_range(0, 4) == 0) pos_pick = PosW'($urandom_range(0, 127));
            else pos_pick = PosW'($urandom_range(0, list_count));
            issue_command(cmd_pick, pos_pick, pick_value(), 0, none);
            pace_sender();
          end
        end
      endcase
      if (kind < 2) begin
        n = $urandom_range(3, 8);
        repeat (n) begin
          cmd_pick = 3'($urandom_range(0, 5));
          pos_pick = $urandom_range(0, 1) ? PosW'($urandom_range(0, Capacity))
                                          : PosW'($urandom_range(0, 127));
          issue_command(cmd_pick, pos_pick, pick_value(), 0, none);
          pace_sender();
        end
      end
      kind = $urandom_range(0, 3);
    end

    in_valid_q <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Catch any stray result after the last one.
    repeat (DrainCycles) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, pending_results.size());
      error_count++;
    end
    $display("tb: %0d list commands (%0d directed), %0d results checked, %0d mismatches",
             list_commands, directed_total, results_checked, error_count);
    $display("tb: full %0d times, empty pop %0d times, out of range %0d times",
             full_hits, empty_hits, range_hits);
    if (error_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin : receiver
    int mode;
    int seg_left;
    int phase;
    int holds_done;
    mode       = 0;
    seg_left   = 0;
    phase      = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      // Hold off long enough for the job queue to fill and stall the input.
      if ((holds_done == 0 && list_commands >= 100) ||
          (holds_done == 1 && list_commands >= 450)) begin
        holds_done++;
        out_ready_q <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 40);
        end
        seg_left--;
        phase++;
        case (mode)
          0:       out_ready_q <= 1'b1;
          1:       out_ready_q <= 1'($urandom_range(0, 1));
          2:       out_ready_q <= ($urandom_range(0, 4) == 0);
          default: out_ready_q <= phase[0];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready_q) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result read_value=%h status=%0d count=%0d",
                 $realtime, read_value_o, status_o, count_o);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        if (read_value_o !== oldest_result.read_value) begin
          $display("%0t: read_value expected %h, got %h",
                   $realtime, oldest_result.read_value, read_value_o);
          error_count++;
        end
        if (status_o !== oldest_result.status) begin
          $display("%0t: status expected %0d, got %0d",
                   $realtime, oldest_result.status, status_o);
          error_count++;
        end
        if (count_o !== oldest_result.count) begin
          $display("%0t: count expected %0d, got %0d",
                   $realtime, oldest_result.count, count_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d results pending",
                 $realtime, idle_cycles, pending_results.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

endmodule
